/* hdl/fqwh_pkg.sv */
// Shared types and constants for the mailbox queue with waiter handoff.
`default_nettype none

package fqwh_pkg;

   localparam int KIND_WIDTH      = 1;
   localparam int ITEM_WIDTH      = 32;
   localparam int REQUESTER_WIDTH = 4;
   localparam int OUTCOME_WIDTH   = 3;
   localparam int VISITED_WIDTH   = 32;
   localparam int HELD_WIDTH      = 5;

   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_TAKE = 1'b1;

   typedef enum logic [OUTCOME_WIDTH-1:0] {
      OUT_RETURNED = 3'd0,
      OUT_PARKED   = 3'd1,
      OUT_HANDED   = 3'd2,
      OUT_STORED   = 3'd3,
      OUT_FULL     = 3'd4
   } outcome_type;

   // Datapath to controller: occupancy flags of both FIFOs.
   typedef struct packed {
      logic item_empty;
      logic item_full;
      logic waiter_empty;
      logic waiter_full;
   } status_type;

   // Controller to datapath: what to do with the current transaction.
   typedef struct packed {
      logic        accept;
      outcome_type outcome;
      logic        load_now;
      logic        load_read;
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/fqwh_if.sv */
// Request and response channel interfaces of the mailbox queue.
`default_nettype none

interface fqwh_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [fqwh_pkg::KIND_WIDTH-1:0]      kind;
   logic [fqwh_pkg::ITEM_WIDTH-1:0]      item;
   logic [fqwh_pkg::REQUESTER_WIDTH-1:0] requester;

   modport source (output valid, kind, item, requester, input ready);
   modport sink (input valid, kind, item, requester, output ready);
endinterface

interface fqwh_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [fqwh_pkg::OUTCOME_WIDTH-1:0]   outcome;
   logic [fqwh_pkg::REQUESTER_WIDTH-1:0] target;
   logic [fqwh_pkg::ITEM_WIDTH-1:0]      data;
   logic [fqwh_pkg::VISITED_WIDTH-1:0]   visited_count;
   logic [fqwh_pkg::HELD_WIDTH-1:0]      items_held;
   logic [fqwh_pkg::HELD_WIDTH-1:0]      waiters_held;

   modport source (output valid, outcome, target, data, visited_count, items_held,
                   waiters_held, input ready);
   modport sink (input valid, outcome, target, data, visited_count, items_held,
                 waiters_held, output ready);
endinterface

`default_nettype wire

/* hdl/fqwh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fqwh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/fqwh_ctrl.sv */
// Controller: request decode, handshake and result-valid sequencing.
`default_nettype none

module fqwh_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_kind,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire fqwh_pkg::status_type status,
   output fqwh_pkg::cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fqwh_pkg::outcome_type outcome;
   logic                  accept;
   logic                  needs_read;

   always_comb begin
      if (req_kind == fqwh_pkg::KIND_PUT) begin
         if (!status.waiter_empty) begin
            outcome = fqwh_pkg::OUT_HANDED;
         end else if (status.item_full) begin
            outcome = fqwh_pkg::OUT_FULL;
         end else begin
            outcome = fqwh_pkg::OUT_STORED;
         end
      end else begin
         if (!status.item_empty) begin
            outcome = fqwh_pkg::OUT_RETURNED;
         end else if (status.waiter_full) begin
            outcome = fqwh_pkg::OUT_FULL;
         end else begin
            outcome = fqwh_pkg::OUT_PARKED;
         end
      end
   end

   assign needs_read = (outcome == fqwh_pkg::OUT_HANDED) ||
                       (outcome == fqwh_pkg::OUT_RETURNED);
   assign req_ready  = !reset && (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;

   always_comb begin
      cmd.accept    = accept;
      cmd.outcome   = outcome;
      cmd.load_now  = accept && !needs_read;
      cmd.load_read = (state_ff == ST_READ);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && needs_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // set on a result load, drop when the sink takes the transaction
   always_comb begin
      if (cmd.load_now || cmd.load_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_read_loads_result: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff == ST_READ) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("read state did not load a result");

   a_no_accept_over_pending: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid_ff) |-> rsp_ready)
      else $error("transaction accepted over an untaken result");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_now && cmd.load_read))
      else $error("two result loads in one cycle");

endmodule

`default_nettype wire

/* hdl/fqwh_datapath.sv */
// Datapath: item and waiter FIFOs, delivered counter and result register.
`default_nettype none

module fqwh_datapath #(
   parameter int ITEM_DEPTH   = 16,
   parameter int WAITER_DEPTH = 16,
   parameter int DATA_WIDTH   = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fqwh_pkg::cmd_type                    cmd,
   output fqwh_pkg::status_type                      status,
   input  wire logic [fqwh_pkg::ITEM_WIDTH-1:0]      req_item,
   input  wire logic [fqwh_pkg::REQUESTER_WIDTH-1:0] req_requester,
   output logic      [fqwh_pkg::OUTCOME_WIDTH-1:0]   rsp_outcome,
   output logic      [fqwh_pkg::REQUESTER_WIDTH-1:0] rsp_target,
   output logic      [fqwh_pkg::ITEM_WIDTH-1:0]      rsp_data,
   output logic      [fqwh_pkg::VISITED_WIDTH-1:0]   rsp_visited_count,
   output logic      [fqwh_pkg::HELD_WIDTH-1:0]      rsp_items_held,
   output logic      [fqwh_pkg::HELD_WIDTH-1:0]      rsp_waiters_held
);

   localparam int IPW = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
   localparam int ICW = $clog2(ITEM_DEPTH + 1);
   localparam int WPW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
   localparam int WCW = $clog2(WAITER_DEPTH + 1);
   localparam int RW  = fqwh_pkg::REQUESTER_WIDTH;

   logic [IPW-1:0] item_rd_ptr_ff, item_rd_ptr_in;
   logic [IPW-1:0] item_wr_ptr_ff, item_wr_ptr_in;
   logic [ICW-1:0] item_count_ff, item_count_in;
   logic [WPW-1:0] waiter_rd_ptr_ff, waiter_rd_ptr_in;
   logic [WPW-1:0] waiter_wr_ptr_ff, waiter_wr_ptr_in;
   logic [WCW-1:0] waiter_count_ff, waiter_count_in;
   logic [fqwh_pkg::VISITED_WIDTH-1:0] delivered_ff, delivered_in;

   fqwh_pkg::outcome_type pend_outcome_ff;
   logic [DATA_WIDTH-1:0] pend_item_ff;
   logic [RW-1:0]         pend_requester_ff;

   logic [fqwh_pkg::OUTCOME_WIDTH-1:0]   outcome_ff;
   logic [RW-1:0]                        target_ff;
   logic [fqwh_pkg::ITEM_WIDTH-1:0]      data_ff;
   logic [fqwh_pkg::VISITED_WIDTH-1:0]   visited_ff;
   logic [fqwh_pkg::HELD_WIDTH-1:0]      items_held_ff;
   logic [fqwh_pkg::HELD_WIDTH-1:0]      waiters_held_ff;

   logic [DATA_WIDTH-1:0] item_masked;
   logic                  do_store, do_return, do_park, do_hand;
   logic [DATA_WIDTH-1:0] item_rd_data;
   logic [RW-1:0]         waiter_rd_data;

   assign item_masked = DATA_WIDTH'(req_item);

   assign do_store  = cmd.accept && (cmd.outcome == fqwh_pkg::OUT_STORED);
   assign do_return = cmd.accept && (cmd.outcome == fqwh_pkg::OUT_RETURNED);
   assign do_park   = cmd.accept && (cmd.outcome == fqwh_pkg::OUT_PARKED);
   assign do_hand   = cmd.accept && (cmd.outcome == fqwh_pkg::OUT_HANDED);

   always_comb begin
      status.item_empty   = (item_count_ff == '0);
      status.item_full    = (item_count_ff == ICW'(ITEM_DEPTH));
      status.waiter_empty = (waiter_count_ff == '0);
      status.waiter_full  = (waiter_count_ff == WCW'(WAITER_DEPTH));
   end

   always_comb begin
      item_rd_ptr_in   = item_rd_ptr_ff;
      item_wr_ptr_in   = item_wr_ptr_ff;
      item_count_in    = item_count_ff;
      waiter_rd_ptr_in = waiter_rd_ptr_ff;
      waiter_wr_ptr_in = waiter_wr_ptr_ff;
      waiter_count_in  = waiter_count_ff;
      delivered_in     = delivered_ff;
      if (do_store) begin
         item_wr_ptr_in = (item_wr_ptr_ff == IPW'(ITEM_DEPTH - 1)) ? '0
                          : item_wr_ptr_ff + 1'b1;
         item_count_in  = item_count_ff + 1'b1;
      end
      if (do_return) begin
         item_rd_ptr_in = (item_rd_ptr_ff == IPW'(ITEM_DEPTH - 1)) ? '0
                          : item_rd_ptr_ff + 1'b1;
         item_count_in  = item_count_ff - 1'b1;
         delivered_in   = delivered_ff + 1'b1;
      end
      if (do_park) begin
         waiter_wr_ptr_in = (waiter_wr_ptr_ff == WPW'(WAITER_DEPTH - 1)) ? '0
                            : waiter_wr_ptr_ff + 1'b1;
         waiter_count_in  = waiter_count_ff + 1'b1;
      end
      if (do_hand) begin
         waiter_rd_ptr_in = (waiter_rd_ptr_ff == WPW'(WAITER_DEPTH - 1)) ? '0
                            : waiter_rd_ptr_ff + 1'b1;
         waiter_count_in  = waiter_count_ff - 1'b1;
         delivered_in     = delivered_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_rd_ptr_ff   <= '0;
         item_wr_ptr_ff   <= '0;
         item_count_ff    <= '0;
         waiter_rd_ptr_ff <= '0;
         waiter_wr_ptr_ff <= '0;
         waiter_count_ff  <= '0;
         delivered_ff     <= '0;
      end else begin
         item_rd_ptr_ff   <= item_rd_ptr_in;
         item_wr_ptr_ff   <= item_wr_ptr_in;
         item_count_ff    <= item_count_in;
         waiter_rd_ptr_ff <= waiter_rd_ptr_in;
         waiter_wr_ptr_ff <= waiter_wr_ptr_in;
         waiter_count_ff  <= waiter_count_in;
         delivered_ff     <= delivered_in;
      end
   end

   fqwh_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (ITEM_DEPTH)
   ) u_item_ram (
      .clock   (clock),
      .wr_en   (do_store),
      .wr_addr (item_wr_ptr_ff),
      .wr_data (item_masked),
      .rd_en   (do_return),
      .rd_addr (item_rd_ptr_ff),
      .rd_data (item_rd_data)
   );

   fqwh_ram #(
      .WIDTH (RW),
      .DEPTH (WAITER_DEPTH)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (do_park),
      .wr_addr (waiter_wr_ptr_ff),
      .wr_data (req_requester),
      .rd_en   (do_hand),
      .rd_addr (waiter_rd_ptr_ff),
      .rd_data (waiter_rd_data)
   );

   // hold the fields that the result needs after the RAM read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_outcome_ff   <= cmd.outcome;
         pend_item_ff      <= item_masked;
         pend_requester_ff <= req_requester;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_now) begin
         outcome_ff      <= cmd.outcome;
         target_ff       <= (cmd.outcome == fqwh_pkg::OUT_PARKED) ? req_requester : '0;
         data_ff         <= '0;
         visited_ff      <= delivered_ff;
         items_held_ff   <= fqwh_pkg::HELD_WIDTH'(item_count_in);
         waiters_held_ff <= fqwh_pkg::HELD_WIDTH'(waiter_count_in);
      end else if (cmd.load_read) begin
         outcome_ff      <= pend_outcome_ff;
         visited_ff      <= delivered_ff;
         items_held_ff   <= fqwh_pkg::HELD_WIDTH'(item_count_ff);
         waiters_held_ff <= fqwh_pkg::HELD_WIDTH'(waiter_count_ff);
         if (pend_outcome_ff == fqwh_pkg::OUT_RETURNED) begin
            target_ff <= pend_requester_ff;
            data_ff   <= fqwh_pkg::ITEM_WIDTH'(item_rd_data);
         end else begin
            target_ff <= waiter_rd_data;
            data_ff   <= fqwh_pkg::ITEM_WIDTH'(pend_item_ff);
         end
      end
   end

   assign rsp_outcome       = outcome_ff;
   assign rsp_target        = target_ff;
   assign rsp_data          = data_ff;
   assign rsp_visited_count = visited_ff;
   assign rsp_items_held    = items_held_ff;
   assign rsp_waiters_held  = waiters_held_ff;

   a_never_both: assert property (@(posedge clock) disable iff (reset)
      !(item_count_ff != '0 && waiter_count_ff != '0))
      else $error("items and waiters held at the same time");

   a_item_bound: assert property (@(posedge clock) disable iff (reset)
      (item_count_ff <= ICW'(ITEM_DEPTH)) && (waiter_count_ff <= WCW'(WAITER_DEPTH)))
      else $error("FIFO count beyond depth");

   a_reject_no_change: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.accept && cmd.outcome == fqwh_pkg::OUT_FULL) |=>
      ($stable(item_count_ff) && $stable(waiter_count_ff) && $stable(delivered_ff)))
      else $error("rejected transaction changed state");

endmodule

`default_nettype wire

/* hdl/fifo_queue_with_waiter_handoff.sv */
// Mailbox queue top level: pairs put transactions with FIFO-ordered waiting takers.
//
// req_bus carries one request per transaction: kind (put or take), the item of a put
// and the requester id of a take. rsp_bus returns exactly one result per request:
// outcome, target requester, delivered data, the running delivered count and the
// occupancy of the item and waiter FIFOs after the request.
// Timing: a store, park or reject result is valid the cycle after acceptance; a
// return or handoff reads the head of an item or waiter RAM, enters the read state,
// and its result is loaded into the result register from there. One request is in
// flight at a time, so a return or handoff also holds req_bus.ready low through the
// read state, which the registered RAM read of the FIFO head makes necessary.
// The result register parts the two sides: a new request is taken in the same cycle
// as the pending result is taken. While rsp_bus stalls, the result holds and
// req_bus.ready stays low.
// Reset clears both FIFOs' pointers and counts and the delivered count; the RAM
// contents are not cleared, since every read hits an entry written earlier.
`default_nettype none

module fifo_queue_with_waiter_handoff #(
   parameter int ITEM_DEPTH   = 16,
   parameter int WAITER_DEPTH = 16,
   parameter int DATA_WIDTH   = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   fqwh_req_if.sink   req_bus,
   fqwh_rsp_if.source rsp_bus
);

   fqwh_pkg::status_type status;
   fqwh_pkg::cmd_type    cmd;
   logic                 req_ready;
   logic                 rsp_valid;

   fqwh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .req_kind  (req_bus.kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fqwh_datapath #(
      .ITEM_DEPTH   (ITEM_DEPTH),
      .WAITER_DEPTH (WAITER_DEPTH),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_item          (req_bus.item),
      .req_requester     (req_bus.requester),
      .rsp_outcome       (rsp_bus.outcome),
      .rsp_target        (rsp_bus.target),
      .rsp_data          (rsp_bus.data),
      .rsp_visited_count (rsp_bus.visited_count),
      .rsp_items_held    (rsp_bus.items_held),
      .rsp_waiters_held  (rsp_bus.waiters_held)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

`default_nettype wire
